[rtl/fm_envelope_generator_ssg_assert.svh]
// Assertion macros for the FM envelope generator checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef FM_ENVELOPE_GENERATOR_SSG_ASSERT_SVH
`define FM_ENVELOPE_GENERATOR_SSG_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FMEG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define FMEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fmeg_pkg.sv]
// Shared types, register indexes and rate tables for the FM envelope generator.
// No dependencies.
package fmeg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SSG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KC_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATK_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUS_RATE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUS_LEVEL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_RATE   = 3'd7;

    localparam logic [6:0]  OUT_OFFSET_RST = 7'd127;
    localparam logic [5:0]  FAST_ATTACK_RATE = 6'd62;
    localparam logic [9:0]  LEVEL_MAX   = 10'h3FF;
    localparam logic [9:0]  SSG_CENTER  = 10'h200;
    localparam logic [9:0]  SL_TOP      = 10'h3E0;
    localparam logic [1:0]  TICK_DIV_RST = 2'd1;
    localparam logic [1:0]  TICK_DIV_TOP = 2'd3;

    localparam logic [7:0] LOW_MASKS  [4] = '{8'hAA, 8'hBA, 8'hEE, 8'hFE};
    localparam logic [7:0] HIGH_MASKS [4] = '{8'h00, 8'h88, 8'hAA, 8'hEE};

    typedef enum logic [3:0] {
        PH_ATTACK  = 4'b0001,
        PH_DECAY   = 4'b0010,
        PH_SUSTAIN = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [3:0] ssg_mode;
        logic [6:0] out_offset;
        logic [1:0] kc_shift;
        logic [4:0] atk_rate;
        logic [4:0] dec_rate;
        logic [4:0] sus_rate;
        logic [3:0] sus_level;
        logic [3:0] rel_rate;
    } cfg_t;

    typedef struct packed {
        logic       cmd;
        logic       key_level;
        logic [4:0] kcode;
    } in_beat_t;

    typedef struct packed {
        logic [9:0] attenuation;
        logic       attack_started;
    } out_beat_t;

    typedef struct packed {
        phase_t      phase;
        logic [9:0]  level;
        logic [1:0]  tick_div;
        logic [10:0] rate_cnt;
        logic [2:0]  delta_step;
        logic        ssg_inv;
        logic        key_held;
    } env_state_t;

    // Effective rate: 2*r plus scaled key code, saturated at 63; zero rate stays zero.
    function automatic logic [5:0] eff_rate(logic [4:0] r, logic [4:0] kc, logic [1:0] ks);
        logic [6:0] sum;
        sum = {1'b0, r, 1'b0} + 7'(kc >> (2'd3 - ks));
        if (r == 5'd0)
            return 6'd0;
        else if (sum > 7'd63)
            return 6'd63;
        else
            return sum[5:0];
    endfunction

    // Level step for a rate and pattern position.
    function automatic logic [3:0] delta_of(logic [5:0] rate, logic [2:0] idx);
        logic [7:0] hm;
        logic [1:0] sh;
        hm = HIGH_MASKS[rate[1:0]];
        sh = 2'(rate[5:2] - 4'd12);
        if (rate < 6'd2)
            return 4'd0;
        else if (rate < 6'd6)
            return {3'd0, LOW_MASKS[0][idx]};
        else if (rate < 6'd8)
            return {3'd0, LOW_MASKS[2][idx]};
        else if (rate < 6'd48)
            return {3'd0, LOW_MASKS[rate[1:0]][idx]};
        else if (rate >= 6'd60)
            return 4'd8;
        else
            return (4'd1 << sh) << hm[idx];
    endfunction

endpackage

[rtl/fm_envelope_generator_ssg.sv]
// An accepted beat passes the input register, then the output register.
// Throughput: one beat per cycle when not stalled, set by the single-pass fmeg_step.
// A second beat is taken into the input register while a result waits stalled.
// Reset (rst_n, async low): phase attack, level 0, tick divider 1, key off,
// output offset 127, other registers 0, both pipeline registers empty.
// Depends on fmeg_pkg and fmeg_step.
module fm_envelope_generator_ssg
    import fmeg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_beat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_beat,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Input register, envelope state, config and output register.
    logic       s1_valid_reg, s1_valid_next;
    in_beat_t   s1_beat_reg;
    logic       out_valid_reg, out_valid_next;
    out_beat_t  out_beat_reg;
    env_state_t state_reg, state_next;
    cfg_t       cfg_reg, cfg_next;
    out_beat_t  step_result;

    logic accept;
    logic s1_fire;

    // The stage fires with a beat held and the output register empty or draining.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    fmeg_step u_step (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .beat      (s1_beat_reg),
        .state_nxt (state_next),
        .result    (step_result)
    );

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Register file decode; the user writes only while the block is idle, unenforced.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SSG_MODE:   cfg_next.ssg_mode   = cfg_data[3:0];
                CFG_OUT_OFFSET: cfg_next.out_offset = cfg_data[6:0];
                CFG_KC_SHIFT:   cfg_next.kc_shift   = cfg_data[1:0];
                CFG_ATK_RATE:   cfg_next.atk_rate   = cfg_data[4:0];
                CFG_DEC_RATE:   cfg_next.dec_rate   = cfg_data[4:0];
                CFG_SUS_RATE:   cfg_next.sus_rate   = cfg_data[4:0];
                CFG_SUS_LEVEL:  cfg_next.sus_level  = cfg_data[3:0];
                CFG_REL_RATE:   cfg_next.rel_rate   = cfg_data[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{ssg_mode: '0, out_offset: OUT_OFFSET_RST, kc_shift: '0,
                               atk_rate: '0, dec_rate: '0, sus_rate: '0,
                               sus_level: '0, rel_rate: '0};
            state_reg     <= '{phase: PH_ATTACK, level: '0, tick_div: TICK_DIV_RST,
                               rate_cnt: '0, delta_step: '0, ssg_inv: 1'b0,
                               key_held: 1'b0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (s1_fire)
                state_reg <= state_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_beat_reg <= in_beat;
        if (s1_fire)
            out_beat_reg <= step_result;
    end

endmodule

[rtl/fmeg_step.sv]
// Next-state and result logic for one envelope beat (tick or key event).
// Depends on fmeg_pkg.
module fmeg_step
    import fmeg_pkg::*;
(
    input  cfg_t       cfg,
    input  env_state_t state_cur,
    input  in_beat_t   beat,
    output env_state_t state_nxt,
    output out_beat_t  result
);

    logic        en, atk, alt, hold, fast;
    logic [4:0]  phase_r;
    logic [5:0]  rate;
    logic [10:0] gate;
    logic [10:0] cnt;
    logic [3:0]  d;
    logic [17:0] inc;
    logic [9:0]  target;
    logic [10:0] lvl11;
    logic [1:0]  td_dec;
    logic [9:0]  shown;
    logic [10:0] sum;
    env_state_t  st;

    assign en   = cfg.ssg_mode[3];
    assign atk  = cfg.ssg_mode[2];
    assign alt  = cfg.ssg_mode[1];
    assign hold = cfg.ssg_mode[0];
    // entering attack at a rate this high skips straight to decay
    assign fast = eff_rate(cfg.atk_rate, beat.kcode, cfg.kc_shift) >= FAST_ATTACK_RATE;

    always_comb
    begin
        st      = state_cur;
        result  = '0;
        phase_r = '0;
        rate    = '0;
        gate    = '0;
        cnt     = '0;
        d       = '0;
        inc     = '0;
        target  = '0;
        lvl11   = '0;
        td_dec  = '0;
        shown   = '0;
        sum     = '0;
        if (beat.cmd)
        begin
            if (beat.key_level != st.key_held)
            begin
                st.key_held = beat.key_level;
                if (beat.key_level)
                begin
                    st.phase = fast ? PH_DECAY : PH_ATTACK;
                    if (fast)
                        st.level = '0;
                end
                else
                begin
                    st.phase   = PH_RELEASE;
                    st.ssg_inv = 1'b0;
                end
                result.attack_started = beat.key_level;
            end
        end
        else
        begin
            // SSG-EG step once the level crosses the midpoint
            if (en && st.level[9])
            begin
                if (alt && (!hold || !st.ssg_inv))
                    st.ssg_inv = !st.ssg_inv;
                if (st.phase != PH_ATTACK)
                begin
                    if (st.phase != PH_RELEASE && !hold)
                    begin
                        st.phase = fast ? PH_DECAY : PH_ATTACK;
                        if (fast)
                            st.level = '0;
                    end
                    else if (st.phase == PH_RELEASE || ((!st.ssg_inv) != atk))
                        st.level = LEVEL_MAX;
                end
            end

            td_dec = st.tick_div - 2'd1;
            st.tick_div = td_dec;
            if (td_dec == 2'd0)
            begin
                case (st.phase)
                    PH_ATTACK:  phase_r = cfg.atk_rate;
                    PH_DECAY:   phase_r = cfg.dec_rate;
                    PH_SUSTAIN: phase_r = cfg.sus_rate;
                    default:    phase_r = {cfg.rel_rate, 1'b1};
                endcase
                rate        = eff_rate(phase_r, beat.kcode, cfg.kc_shift);
                gate        = (rate[5:2] < 4'd11) ? (11'h7FF >> rate[5:2]) : 11'd0;
                cnt         = st.rate_cnt;
                st.tick_div = TICK_DIV_TOP;
                st.rate_cnt = cnt + 11'd1;
                if ((cnt & gate) == 11'd0)
                begin
                    d             = delta_of(rate, st.delta_step);
                    st.delta_step = st.delta_step + 3'd1;
                    if (st.phase == PH_ATTACK)
                    begin
                        inc      = {4'hF, ~st.level} * d;
                        st.level = st.level + inc[13:4];
                        if (st.level == 10'd0)
                            st.phase = PH_DECAY;
                    end
                    else
                    begin
                        target = (cfg.sus_level == 4'hF) ? SL_TOP
                                                         : {1'b0, cfg.sus_level, 5'd0};
                        lvl11  = {1'b0, st.level};
                        if (en)
                        begin
                            if (!st.level[9])
                                lvl11 = lvl11 + {5'd0, d, 2'd0};
                        end
                        else
                            lvl11 = lvl11 + {7'd0, d};
                        if (st.phase == PH_DECAY && lvl11 >= {1'b0, target})
                            st.phase = PH_SUSTAIN;
                        st.level = (lvl11 > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : lvl11[9:0];
                    end
                end
            end

            // inverted view around the midpoint
            if (en && st.phase != PH_RELEASE && st.ssg_inv != atk)
                shown = SSG_CENTER - st.level;
            else
                shown = st.level;
            sum = {1'b0, shown} + {1'b0, cfg.out_offset, 3'd0};
            result.attenuation = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[9:0];
        end
        state_nxt = st;
    end

endmodule

[rtl/fmeg_checker.sv]
// Port-level checker for the FM envelope generator, bound to the top level.
// Depends on fmeg_pkg and fm_envelope_generator_ssg_assert.svh.
`include "fm_envelope_generator_ssg_assert.svh"

module fmeg_checker
    import fmeg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_beat
);

    // a key-on beat never carries an attenuation
    `FMEG_ASSERT_SAME(a_key_beat_no_atten, out_valid && out_beat.attack_started, out_beat.attenuation == 10'd0, "attack beat with nonzero attenuation")

    // input side is never held back unless the output side is stalled
    `FMEG_ASSERT_SAME(a_no_needless_stall, !out_valid || !out_stall, !in_stall, "input stalled while output free")

    // a stalled result stays put
    `FMEG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat), "stalled output beat changed")

    // an accepted beat finds a result waiting once it is past the input register
    `FMEG_ASSERT_NEXT(a_accept_to_out, in_valid && !in_stall, ##1 out_valid, "accepted beat did not reach the output")

endmodule

bind fm_envelope_generator_ssg fmeg_checker u_fmeg_checker (.*);

[tb/fm_envelope_generator_ssg_check.sv]
// Checker for the FM envelope generator: watches the input, output and register ports,
// predicts each result beat and compares it field by field.
// Depends on fmeg_pkg for the beat, register and phase types.
module fm_envelope_generator_ssg_check
    import fmeg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_beat_t              in_beat,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_beat_t             out_beat,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fails,
    output int                    pending,
    output int                    checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Step patterns, entry 0 in the low byte.
    localparam logic [3:0][7:0] SLOW_PAT = {8'hFE, 8'hEE, 8'hBA, 8'hAA};
    localparam logic [3:0][7:0] FAST_PAT = {8'hEE, 8'hAA, 8'h88, 8'h00};

    cfg_t        regs;
    phase_t      ph;
    logic [9:0]  lvl;
    logic [1:0]  div;
    logic [10:0] rcnt;
    logic [2:0]  dstep;
    logic        inv;
    logic        held;
    out_beat_t   attenuation_q[$];

    // Phase rate plus key scaling, saturated at 63.
    function automatic int rate_now(logic [4:0] kc);
        int r;
        int sum;
        case (ph)
            PH_ATTACK:  r = int'(regs.atk_rate);
            PH_DECAY:   r = int'(regs.dec_rate);
            PH_SUSTAIN: r = int'(regs.sus_rate);
            default:    r = 2 * int'(regs.rel_rate) + 1;
        endcase
        if (r == 0)
            return 0;
        sum = 2 * r + int'(kc) / (8 >> regs.kc_shift);
        return (sum > 63) ? 63 : sum;
    endfunction

    function automatic int step_size(int rate, int idx);
        logic [7:0] pat;
        if (rate < 2)
            return 0;
        if (rate >= 60)
            return 8;
        if (rate >= 48)
            return (1 << ((rate - 48) / 4)) << FAST_PAT[rate % 4][idx];
        if (rate < 6)
            pat = 8'hAA;
        else if (rate < 8)
            pat = 8'hEE;
        else
            pat = SLOW_PAT[rate % 4];
        return int'(pat[idx]);
    endfunction

    // A fast enough attack skips straight to decay at full volume.
    function automatic void start_attack(logic [4:0] kc);
        ph = PH_ATTACK;
        if (rate_now(kc) >= 62)
        begin
            ph  = PH_DECAY;
            lvl = '0;
        end
    endfunction

    function automatic out_beat_t predict_envelope(in_beat_t b);
        out_beat_t r;
        logic en, atk, alt, hold;
        int rate, gate, d, nxt, target, shown, total;
        logic [10:0] cnt;
        r    = '0;
        en   = regs.ssg_mode[3];
        atk  = regs.ssg_mode[2];
        alt  = regs.ssg_mode[1];
        hold = regs.ssg_mode[0];

        if (b.cmd)
        begin
            // key event; a repeated level is a no-op
            if (b.key_level != held)
            begin
                held = b.key_level;
                if (b.key_level)
                begin
                    start_attack(b.kcode);
                    r.attack_started = 1'b1;
                end
                else
                begin
                    ph  = PH_RELEASE;
                    inv = 1'b0;
                end
            end
            return r;
        end

        if (en && lvl >= 10'h200)
        begin
            if (alt && (!hold || !inv))
                inv = !inv;
            if (ph != PH_ATTACK)
            begin
                if (ph != PH_RELEASE && !hold)
                    start_attack(b.kcode);
                else if (ph == PH_RELEASE || (!inv) != atk)
                    lvl = 10'h3FF;
            end
        end

        div = div - 2'd1;
        if (div == 2'd0)
        begin
            rate = rate_now(b.kcode);
            gate = (rate / 4 < 11) ? (1 << (11 - rate / 4)) - 1 : 0;
            cnt  = rcnt;
            div  = 2'd3;
            rcnt = rcnt + 11'd1;
            if ((int'(cnt) & gate) == 0)
            begin
                d     = step_size(rate, int'(dstep));
                dstep = dstep + 3'd1;
                if (ph == PH_ATTACK)
                begin
                    nxt = (int'(lvl) + (((16383 - int'(lvl)) * d) >> 4)) & 1023;
                    lvl = nxt[9:0];
                    if (lvl == 10'd0)
                        ph = PH_DECAY;
                end
                else
                begin
                    target = (regs.sus_level == 4'd15) ? 'h3E0 : int'(regs.sus_level) * 32;
                    nxt    = int'(lvl);
                    if (en)
                    begin
                        if (nxt < 'h200)
                            nxt += d * 4;
                    end
                    else
                    begin
                        nxt += d;
                    end
                    if (ph == PH_DECAY && nxt >= target)
                        ph = PH_SUSTAIN;
                    lvl = (nxt > 1023) ? 10'h3FF : nxt[9:0];
                end
            end
        end

        shown = int'(lvl);
        if (en && ph != PH_RELEASE && inv != atk)
            shown = ('h200 - int'(lvl)) & 1023;
        total = shown + 8 * int'(regs.out_offset);
        r.attenuation = (total > 1023) ? 10'h3FF : total[9:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            regs            = '0;
            regs.out_offset = OUT_OFFSET_RST;
            ph      = PH_ATTACK;
            lvl     = '0;
            div     = TICK_DIV_RST;
            rcnt    = '0;
            dstep   = '0;
            inv     = 1'b0;
            held    = 1'b0;
            attenuation_q.delete();
            fails   = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SSG_MODE:   regs.ssg_mode   = cfg_data[3:0];
                    CFG_OUT_OFFSET: regs.out_offset = cfg_data[6:0];
                    CFG_KC_SHIFT:   regs.kc_shift   = cfg_data[1:0];
                    CFG_ATK_RATE:   regs.atk_rate   = cfg_data[4:0];
                    CFG_DEC_RATE:   regs.dec_rate   = cfg_data[4:0];
                    CFG_SUS_RATE:   regs.sus_rate   = cfg_data[4:0];
                    CFG_SUS_LEVEL:  regs.sus_level  = cfg_data[3:0];
                    CFG_REL_RATE:   regs.rel_rate   = cfg_data[3:0];
                    default: ;
                endcase
            end

            // compare before queuing: a result never leaves in its own input's cycle
            if (out_valid && !out_stall)
            begin
                if (attenuation_q.size() == 0)
                begin
                    $display("%0t ns: expected no result beat, got attenuation %0d start %0b",
                             $time, out_beat.attenuation, out_beat.attack_started);
                    fails++;
                end
                else
                begin
                    want = attenuation_q.pop_front();
                    checked++;
                    if (out_beat.attenuation !== want.attenuation)
                    begin
                        $display("%0t ns: attenuation expected %0d, got %0d",
                                 $time, want.attenuation, out_beat.attenuation);
                        fails++;
                    end
                    if (out_beat.attack_started !== want.attack_started)
                    begin
                        $display("%0t ns: attack_started expected %0b, got %0b",
                                 $time, want.attack_started, out_beat.attack_started);
                        fails++;
                    end
                end
            end

            if (in_valid && !in_stall)
                attenuation_q.push_back(predict_envelope(in_beat));
            pending = attenuation_q.size();
        end
    end

endmodule

[tb/fm_envelope_generator_ssg_tb.sv]
// Top of the FM envelope generator testbench: clock, reset, register programming,
// directed and random beats, random stalls, watchdog and verdict.
// Depends on fmeg_pkg, fm_envelope_generator_ssg and fm_envelope_generator_ssg_check.
module fm_envelope_generator_ssg_tb
    import fmeg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Input beat codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;
    localparam logic KEY_OFF  = 1'b0;
    localparam logic KEY_ON   = 1'b1;

    // Cycles with no beat moved on either side before the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_beat_t              in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_beat_t             out_beat;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   fails;
    int   pending;
    int   checked;

    // Stimulus-side bookkeeping.
    logic quiet    = 1'b0;   // no idles and no stalls while set
    logic key_now  = KEY_OFF;
    int   n_ticks  = 0;
    int   n_keys   = 0;
    int   n_setups = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fm_envelope_generator_ssg dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fm_envelope_generator_ssg_check envelope_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .checked   (checked)
    );

    // Receiver back-pressure: roughly one cycle in nine, none in the quiet stretch.
    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 11);

    function automatic in_beat_t beat(logic cmd, logic lvl, logic [4:0] kc);
        in_beat_t b;
        b.cmd       = cmd;
        b.key_level = lvl;
        b.kcode     = kc;
        return b;
    endfunction

    // Present one beat, possibly after a few idle cycles, and hold it until taken.
    // Valid stays high on return so back-to-back beats see no bubble.
    task automatic send(input in_beat_t b);
        while (!quiet && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (b.cmd == CMD_KEY)
            n_keys++;
        else
            n_ticks++;
    endtask

    // Stop sending and wait for every outstanding result, then wait out both
    // pipeline registers with a small margin. Sampled on the falling edge so
    // the checker's count has settled.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write all eight registers back to back; only called with the block idle.
    task automatic apply_settings(input cfg_t c);
        put(CFG_SSG_MODE,   CFG_DATA_W'(c.ssg_mode));
        put(CFG_OUT_OFFSET, CFG_DATA_W'(c.out_offset));
        put(CFG_KC_SHIFT,   CFG_DATA_W'(c.kc_shift));
        put(CFG_ATK_RATE,   CFG_DATA_W'(c.atk_rate));
        put(CFG_DEC_RATE,   CFG_DATA_W'(c.dec_rate));
        put(CFG_SUS_RATE,   CFG_DATA_W'(c.sus_rate));
        put(CFG_SUS_LEVEL,  CFG_DATA_W'(c.sus_level));
        put(CFG_REL_RATE,   CFG_DATA_W'(c.rel_rate));
        cfg_wr_en <= 1'b0;
        n_setups++;
    endtask

    // Random register set, leaning toward fast rates and a small output offset
    // so envelopes actually move and the attenuation is not pinned at 1023.
    function automatic cfg_t random_settings();
        cfg_t c;
        c.ssg_mode   = 4'($urandom_range(15));
        c.out_offset = 7'(($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(24));
        c.kc_shift   = 2'($urandom_range(3));
        c.atk_rate   = 5'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(31, 18));
        c.dec_rate   = 5'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(31, 16));
        c.sus_rate   = 5'($urandom_range(31));
        c.sus_level  = 4'($urandom_range(15));
        c.rel_rate   = 4'($urandom_range(15));
        return c;
    endfunction

    // Mostly ticks with the odd key event. Key events usually flip the key so
    // that attack / decay / sustain / release sequences play out; the rest
    // repeat the current level or pick one at random.
    task automatic random_run(input int count, input int key_pct);
        in_beat_t b;
        int       k;
        for (k = 0; k < count; k++)
        begin
            b.kcode = 5'($urandom_range(31));
            if ($urandom_range(99) < key_pct)
            begin
                b.cmd       = CMD_KEY;
                b.key_level = ($urandom_range(9) < 7) ? !key_now : 1'($urandom_range(1));
                key_now     = b.key_level;
            end
            else
            begin
                b.cmd       = CMD_TICK;
                b.key_level = 1'($urandom_range(1));   // don't-care on ticks
            end
            send(b);
        end
    endtask

    // Hang detector: counts cycles in which no beat moves on either channel.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 HANG_LIMIT, pending);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t plan;
        int   p;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: offset 127 dominates the output, attack rate 0
        // keeps the envelope frozen even after a key on.
        send(beat(CMD_TICK, KEY_OFF, 5'd0));
        send(beat(CMD_TICK, KEY_ON,  5'd31));
        send(beat(CMD_KEY,  KEY_ON,  5'd5));
        send(beat(CMD_TICK, KEY_OFF, 5'd31));
        key_now = KEY_ON;
        settle();

        // Fields: ssg mode, output offset, key code shift, attack, decay,
        // sustain rate, sustain target, release. Max rates with full key scaling:
        // key on skips the attack, decay runs at the top step, release at rate 31.
        plan = {4'd0, 7'd0, 2'd3, 5'd31, 5'd31, 5'd31, 4'd15, 4'd15};
        apply_settings(plan);
        send(beat(CMD_KEY,  KEY_OFF, 5'd0));    // key off from on: release
        send(beat(CMD_KEY,  KEY_ON,  5'd31));   // instant attack
        send(beat(CMD_KEY,  KEY_ON,  5'd0));    // same level again: no effect
        send(beat(CMD_TICK, KEY_OFF, 5'd31));
        send(beat(CMD_TICK, KEY_ON,  5'd31));
        send(beat(CMD_TICK, KEY_OFF, 5'd31));
        send(beat(CMD_TICK, KEY_ON,  5'd0));
        send(beat(CMD_TICK, KEY_OFF, 5'd31));
        send(beat(CMD_KEY,  KEY_OFF, 5'd0));
        send(beat(CMD_KEY,  KEY_OFF, 5'd31));   // repeated key off
        send(beat(CMD_TICK, KEY_ON,  5'd0));
        send(beat(CMD_TICK, KEY_OFF, 5'd0));
        key_now = KEY_OFF;
        settle();

        // SSG enabled with the attack bit set: the level is shown inverted
        // around 0x200 while a moderate attack ramps it down.
        plan = {4'd12, 7'd0, 2'd0, 5'd12, 5'd31, 5'd0, 4'd0, 4'd0};
        apply_settings(plan);
        send(beat(CMD_KEY,  KEY_ON,  5'd0));
        send(beat(CMD_TICK, KEY_OFF, 5'd31));
        send(beat(CMD_TICK, KEY_ON,  5'd0));
        send(beat(CMD_TICK, KEY_OFF, 5'd31));
        send(beat(CMD_TICK, KEY_ON,  5'd0));
        send(beat(CMD_TICK, KEY_OFF, 5'd31));
        send(beat(CMD_TICK, KEY_ON,  5'd0));
        key_now = KEY_ON;
        settle();

        // Random part: first every register at its maximum, then all zero,
        // then random sets. One phase runs with no idles and no stalls.
        for (p = 0; p < 10; p++)
        begin
            if (p == 0)
                plan = {4'd15, 7'd127, 2'd3, 5'd31, 5'd31, 5'd31, 4'd15, 4'd15};
            else if (p == 1)
                plan = '0;
            else
                plan = random_settings();
            apply_settings(plan);
            quiet = (p == 5);
            random_run((p < 2) ? 120 : 210, (p % 2 == 0) ? 3 : 10);
            settle();
        end
        quiet = 1'b0;

        $display("run covered %0d ticks and %0d key events over %0d register settings",
                 n_ticks, n_keys, n_setups);
        $display("%0d result beats compared, %0d mismatches", checked, fails);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
